FILE: sv/spdg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dense-graph shortest path core.
// No dependencies.
package spdg_pkg;

  localparam int INDEX_BITS    = 4;
  localparam int IN_WEIGHT_BITS = 16;
  localparam int DIST_BITS     = 20;

  localparam logic [DIST_BITS-1:0] DIST_INF = '1;

  typedef struct packed {
    logic [INDEX_BITS-1:0]     row_index;
    logic [INDEX_BITS-1:0]     col_index;
    logic [IN_WEIGHT_BITS-1:0] edge_weight;
    logic                      last_entry;
  } in_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] vertex_id;
    logic [DIST_BITS-1:0]  path_length;
    logic                  reachable;
    logic                  last_result;
  } out_t;

  // Write-back decision of one relaxation step
  typedef struct packed {
    logic                 upd;
    logic                 vis;
    logic [DIST_BITS-1:0] path_len;
  } relax_t;

endpackage

FILE: sv/shortest_path_dense_graph_core.sv
`timescale 1ns / 1ps
// Loading: one matrix entry per cycle while in the load state. A last entry
// starts the search: the distance memory is initialized, then each round runs
// a minimum scan and a relaxation pass, at most NUM_VERTICES-1 rounds, each pass
// walking the vertices through the single read port of each memory.
// Results then leave one per vertex, the next only after the sink takes the last.
// Reset clears control only; memory contents are undefined until written.
module shortest_path_dense_graph_core #(
  parameter int NUM_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            entry_valid,
  output logic            entry_ready,
  input  spdg_pkg::in_t   entry,
  output logic            result_valid,
  input  logic            result_ready,
  output spdg_pkg::out_t  result
);

  localparam int VB = $clog2(NUM_VERTICES);
  localparam int DB = spdg_pkg::DIST_BITS;
  localparam logic [VB-1:0] LASTV = VB'(NUM_VERTICES - 1);
  localparam logic [VB-1:0] LAST_ROUND = VB'(NUM_VERTICES - 2);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_SEL   = 4'd2;
  localparam logic [3:0] S_SELW  = 4'd3;
  localparam logic [3:0] S_PICK  = 4'd4;
  localparam logic [3:0] S_REL   = 4'd5;
  localparam logic [3:0] S_RELW  = 4'd6;
  localparam logic [3:0] S_ORD   = 4'd7;
  localparam logic [3:0] S_OWAIT = 4'd8;
  localparam logic [3:0] S_OHOLD = 4'd9;

  logic [3:0]    state;
  logic [VB-1:0] cnt;
  logic [VB-1:0] round;
  logic          pv;
  logic [VB-1:0] pa;
  logic [DB-1:0] least;
  logic [VB-1:0] best;
  logic          found;

  logic               entry_acc;
  logic               in_range;
  logic               wwr_en;
  logic [2*VB-1:0]    wwr_addr;
  logic [WEIGHT_BITS-1:0] wwr_data;
  logic [2*VB-1:0]    wrd_addr;
  logic [WEIGHT_BITS-1:0] wrd_data;

  logic               dwr_en;
  logic [VB-1:0]      dwr_addr;
  logic [DB:0]        dwr_data;
  logic [DB:0]        drd_data;
  logic               dvis;
  logic [DB-1:0]      dval;
  logic               reach;

  spdg_pkg::relax_t   rlx;

  assign entry_ready = (state == S_LOAD);
  assign entry_acc   = entry_valid && entry_ready;
  assign in_range    = (32'(entry.row_index) < NUM_VERTICES) &&
                       (32'(entry.col_index) < NUM_VERTICES);

  assign wwr_en   = entry_acc && in_range;
  assign wwr_addr = {VB'(entry.row_index), VB'(entry.col_index)};
  assign wwr_data = WEIGHT_BITS'(entry.edge_weight);
  assign wrd_addr = {best, cnt};

  assign dvis  = drd_data[DB];
  assign dval  = drd_data[DB-1:0];
  assign reach = (dval != spdg_pkg::DIST_INF);

  spdg_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (2 ** (2 * VB))
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (wwr_en),
    .wr_addr (wwr_addr),
    .wr_data (wwr_data),
    .rd_addr (wrd_addr),
    .rd_data (wrd_data)
  );

  spdg_ram #(
    .WIDTH (DB + 1),
    .DEPTH (NUM_VERTICES)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (dwr_en),
    .wr_addr (dwr_addr),
    .wr_data (dwr_data),
    .rd_addr (cnt),
    .rd_data (drd_data)
  );

  spdg_relax #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_relax (
    .du       (least),
    .w        (wrd_data),
    .d        (dval),
    .vis      (dvis),
    .self_hit (pa == best),
    .rlx      (rlx)
  );

  // Distance memory write port: init sweep or relaxation write-back
  always_comb begin
    dwr_en   = 1'b0;
    dwr_addr = cnt;
    dwr_data = {1'b0, spdg_pkg::DIST_INF};
    if (state == S_INIT) begin
      dwr_en   = 1'b1;
      dwr_data = {1'b0, (cnt == '0) ? {DB{1'b0}} : spdg_pkg::DIST_INF};
    end else if ((state == S_REL || state == S_RELW) && pv && rlx.upd) begin
      dwr_en   = 1'b1;
      dwr_addr = pa;
      dwr_data = {rlx.vis, rlx.path_len};
    end
  end

  always_ff @(posedge clk) begin
    pa <= cnt;
    if ((state == S_SEL || state == S_SELW) && pv && !dvis && (dval < least)) begin
      least <= dval;
      best  <= pa;
    end
    if (state == S_OWAIT) begin
      result.vertex_id   <= spdg_pkg::INDEX_BITS'(cnt);
      result.path_length <= reach ? dval : '0;
      result.reachable   <= reach;
      result.last_result <= (cnt == LASTV);
    end
    if (state == S_INIT && cnt == LASTV) begin
      least <= spdg_pkg::DIST_INF;
    end
    if (state == S_RELW && round != LAST_ROUND) begin
      least <= spdg_pkg::DIST_INF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      cnt          <= '0;
      round        <= '0;
      pv           <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      pv <= (state == S_SEL) || (state == S_REL) || (state == S_ORD);
      if ((state == S_SEL || state == S_SELW) && pv && !dvis && (dval < least)) begin
        found <= 1'b1;
      end
      case (state)
        S_LOAD: begin
          if (entry_acc && entry.last_entry) begin
            cnt   <= '0;
            round <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LASTV) begin
            cnt   <= '0;
            found <= 1'b0;
            state <= S_SEL;
          end
        end
        S_SEL: begin
          cnt <= cnt + 1'b1;
          if (cnt == LASTV) begin
            cnt   <= '0;
            state <= S_SELW;
          end
        end
        S_SELW: begin
          state <= S_PICK;
        end
        S_PICK: begin
          // no reachable unvisited vertex left: stop early
          state <= found ? S_REL : S_ORD;
        end
        S_REL: begin
          cnt <= cnt + 1'b1;
          if (cnt == LASTV) begin
            cnt   <= '0;
            state <= S_RELW;
          end
        end
        S_RELW: begin
          if (round == LAST_ROUND) begin
            state <= S_ORD;
          end else begin
            round <= round + 1'b1;
            found <= 1'b0;
            state <= S_SEL;
          end
        end
        S_ORD: begin
          state <= S_OWAIT;
        end
        S_OWAIT: begin
          result_valid <= 1'b1;
          state        <= S_OHOLD;
        end
        S_OHOLD: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (cnt == LASTV) begin
              cnt   <= '0;
              state <= S_LOAD;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    entry_ready |-> !result_valid)
    else $error("entry accepted while a result beat is pending");

  a_load_no_dist_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !dwr_en)
    else $error("distance memory written while loading");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL || state == S_REL) |-> (round <= LAST_ROUND))
    else $error("search ran past the round limit");

  a_last_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result.last_result) |=> entry_ready)
    else $error("block did not return to loading after the last result beat");

endmodule

FILE: sv/spdg_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/spdg_relax.sv
`timescale 1ns / 1ps
// Edge relaxation: saturating candidate distance and the write-back decision.
// Depends on spdg_pkg.
module spdg_relax #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic [spdg_pkg::DIST_BITS-1:0] du,
  input  logic [WEIGHT_BITS-1:0]         w,
  input  logic [spdg_pkg::DIST_BITS-1:0] d,
  input  logic                           vis,
  input  logic                           self_hit,
  output spdg_pkg::relax_t               rlx
);

  localparam int SW = (WEIGHT_BITS > spdg_pkg::DIST_BITS ? WEIGHT_BITS
                                                         : spdg_pkg::DIST_BITS) + 1;

  logic [SW-1:0]                  sum;
  logic [spdg_pkg::DIST_BITS-1:0] cand;

  always_comb begin
    sum  = SW'(du) + SW'(w);
    // clamp just below the infinite code
    cand = (sum >= SW'(spdg_pkg::DIST_INF)) ? spdg_pkg::DIST_INF - 1'b1
                                            : sum[spdg_pkg::DIST_BITS-1:0];
    rlx.vis      = 1'b0;
    rlx.path_len = cand;
    rlx.upd      = 1'b0;
    if (self_hit) begin
      // mark the picked vertex visited, keep its distance
      rlx.upd      = 1'b1;
      rlx.vis      = 1'b1;
      rlx.path_len = d;
    end else if (!vis && (w != '0) && (cand < d)) begin
      rlx.upd = 1'b1;
    end
  end

endmodule

FILE: dv/shortest_path_dense_graph_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shortest_path_dense_graph_core: loads adjacency entries,
// triggers searches and checks every per-vertex distance beat against a local predictor.
// Depends on spdg_pkg and the core RTL.
module shortest_path_dense_graph_core_tb;
  import spdg_pkg::*;

  localparam int NV             = 1 << INDEX_BITS;
  localparam int DIRECTED_COUNT = NV + 1;
  localparam int RANDOM_ENTRIES = 153;
  localparam int LONG_HOLD      = 1500;
  localparam int DRAIN_SESSION  = 5;

  // Keeps a copy of the matrix and the distances each search must report
  class distance_board;
    logic [IN_WEIGHT_BITS-1:0] weights [NV][NV];
    out_t expected_dists [$];
    int unsigned errors;
    int unsigned searches;
    int unsigned checked;

    function new();
      errors   = 0;
      searches = 0;
      checked  = 0;
    endfunction

    function int unsigned pending();
      return expected_dists.size();
    endfunction

    function void solve_paths();
      logic [DIST_BITS-1:0] best_len [NV];
      bit seen [NV];
      logic [DIST_BITS:0] cand;
      logic [DIST_BITS-1:0] least;
      int u;
      bit stuck;
      out_t r;
      for (int v = 0; v < NV; v++) begin
        best_len[v] = DIST_INF;
        seen[v] = 1'b0;
      end
      best_len[0] = '0;
      stuck = 1'b0;
      for (int round = 0; round < NV - 1; round++) begin
        if (!stuck) begin
          u = -1;
          least = DIST_INF;
          for (int i = 0; i < NV; i++) begin
            if (!seen[i] && best_len[i] < least) begin
              least = best_len[i];
              u = i;
            end
          end
          if (u < 0) begin
            // nothing finite left unvisited: stop early
            stuck = 1'b1;
          end else begin
            seen[u] = 1'b1;
            for (int v = 0; v < NV; v++) begin
              if (!seen[v] && weights[u][v] != '0) begin
                cand = {1'b0, best_len[u]} + weights[u][v];
                if (cand >= DIST_INF) cand = {1'b0, DIST_INF - 1'b1};
                if (cand < best_len[v]) best_len[v] = cand[DIST_BITS-1:0];
              end
            end
          end
        end
      end
      for (int v = 0; v < NV; v++) begin
        r.vertex_id   = v[INDEX_BITS-1:0];
        r.reachable   = (best_len[v] != DIST_INF);
        r.path_length = r.reachable ? best_len[v] : '0;
        r.last_result = (v == NV - 1);
        expected_dists.push_back(r);
      end
    endfunction

    function void note_entry(input in_t e);
      weights[e.row_index][e.col_index] = e.edge_weight;
      if (e.last_entry) begin
        searches++;
        solve_paths();
      end
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (expected_dists.size() == 0) begin
        errors++;
        $error("result beat with no distance pending: vertex_id %0d path_length %0d",
               got.vertex_id, got.path_length);
        return;
      end
      want = expected_dists.pop_front();
      checked++;
      if (got.vertex_id !== want.vertex_id) begin
        errors++;
        $error("vertex_id: expected %0d, got %0d", want.vertex_id, got.vertex_id);
      end
      if (got.path_length !== want.path_length) begin
        errors++;
        $error("path_length: expected %0d, got %0d", want.path_length, got.path_length);
      end
      if (got.reachable !== want.reachable) begin
        errors++;
        $error("reachable: expected %0b, got %0b", want.reachable, got.reachable);
      end
      if (got.last_result !== want.last_result) begin
        errors++;
        $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
      end
    endfunction
  endclass

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic entry_valid  = 1'b0;
  in_t  entry        = '0;
  logic result_ready = 1'b0;
  logic entry_ready;
  logic result_valid;
  out_t result;

  distance_board sb = new();

  // Which entries hold a written value; a row is searchable only once complete
  bit          written [NV][NV];
  bit [NV-1:0] row_full = '0;
  int unsigned entries_sent = 0;
  int unsigned sessions = 0;
  int unsigned hold_cycles = 0;

  shortest_path_dense_graph_core #(
    .NUM_VERTICES(NV),
    .WEIGHT_BITS (IN_WEIGHT_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (entry_valid),
    .entry_ready (entry_ready),
    .entry       (entry),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [IN_WEIGHT_BITS-1:0] pick_weight();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 25) return '1;
    if (sel < 40) return IN_WEIGHT_BITS'(1);
    if (sel < 80) return IN_WEIGHT_BITS'($urandom_range(1, 8));
    return IN_WEIGHT_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic in_t make_entry(input int r, input int c,
                                     input logic [IN_WEIGHT_BITS-1:0] w, input bit is_last);
    in_t e;
    e.row_index   = r[INDEX_BITS-1:0];
    e.col_index   = c[INDEX_BITS-1:0];
    e.edge_weight = w;
    e.last_entry  = is_last;
    return e;
  endfunction

  function automatic void mark_written(input int r, input int c);
    bit row_done;
    written[r][c] = 1'b1;
    row_done = 1'b1;
    for (int k = 0; k < NV; k++) row_done &= written[r][k];
    row_full[r] = row_done;
  endfunction

  // Nonzero weights only point at complete rows, so a search never reaches a row
  // with holes in it.
  function automatic in_t next_entry(input bit is_last);
    int r, c;
    bit found;
    found = 1'b0;
    r = 0;
    c = 0;
    if ($urandom_range(0, 99) < 75) begin
      for (int i = 0; i < NV * NV; i++) begin
        if (!found && !written[i / NV][i % NV]) begin
          r = i / NV;
          c = i % NV;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      if ($urandom_range(0, 9) < 7) begin
        do r = $urandom_range(0, NV - 1); while (!row_full[r]);
        do c = $urandom_range(0, NV - 1); while (!row_full[c]);
      end else begin
        r = $urandom_range(0, NV - 1);
        c = $urandom_range(0, NV - 1);
      end
    end
    return make_entry(r, c, row_full[c] ? pick_weight() : '0, is_last);
  endfunction

  task automatic send_entry(input in_t e);
    entry       <= e;
    entry_valid <= 1'b1;
    @(posedge clk);
    while (!entry_ready) @(posedge clk);
    mark_written(int'(e.row_index), int'(e.col_index));
    sb.note_entry(e);
    entries_sent++;
  endtask

  // Drop valid for a random gap; on drain, hold until every distance is back
  task automatic rest_after_beat(input bit calm, input bit drain);
    int unsigned n;
    n = 0;
    if (!calm && $urandom_range(0, 9) < 3) n = gap_len();
    if (drain || n != 0) begin
      entry_valid <= 1'b0;
      repeat (n) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (sb.pending() != 0);
      end
    end
  endtask

  initial begin : stimulus
    bit calm;
    bit drain;
    int unsigned len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Row 0 alone: self loop at full weight is ignored, nothing else is reachable
    for (int c = 0; c < NV; c++) begin
      send_entry(make_entry(0, c, (c == 0) ? '1 : '0, c == NV - 1));
      rest_after_beat(1'b0, 1'b0);
    end
    // One-beat load that only rewrites an entry and restarts the search
    send_entry(make_entry(0, 0, '0, 1'b1));
    rest_after_beat(1'b0, 1'b0);

    while (entries_sent < DIRECTED_COUNT + RANDOM_ENTRIES) begin
      sessions++;
      calm = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 24);
      if (len > DIRECTED_COUNT + RANDOM_ENTRIES - entries_sent) begin
        len = DIRECTED_COUNT + RANDOM_ENTRIES - entries_sent;
      end
      for (int i = 0; i < len; i++) begin
        send_entry(next_entry(i == len - 1));
        drain = (i == len - 1) &&
                (sessions == DRAIN_SESSION ||
                 entries_sent >= DIRECTED_COUNT + RANDOM_ENTRIES);
        rest_after_beat(calm, drain);
      end
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Loaded %0d matrix entries in %0d searches (%0d rows complete),",
             entries_sent, sb.searches, $countones(row_full));
    $display("%0d distances checked.", sb.checked);
    $display("Result sink held off for %0d cycles once with loads queued behind it.", hold_cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : sink
    int unsigned stall_left;
    int unsigned calm_left;
    bit hold_done;
    stall_left = 0;
    calm_left  = 0;
    hold_done  = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) sb.check_result(result);
      if (stall_left != 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (!hold_done && sb.searches >= 3 && result_valid) begin
        // hold off long enough for the core to back up into its input
        hold_done   = 1'b1;
        stall_left  = LONG_HOLD;
        hold_cycles = LONG_HOLD;
        result_ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        result_ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_left = 120;
        result_ready <= 1'b1;
      end else if ($urandom_range(0, 9) < 3) begin
        stall_left = gap_len();
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(20_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: shortest_path_dense_graph_core.f
sv/spdg_pkg.sv
sv/spdg_ram.sv
sv/spdg_relax.sv
sv/shortest_path_dense_graph_core.sv
dv/shortest_path_dense_graph_core_tb.sv
